@@ rtl/core/gsc_pkg.sv @@
package gsc_pkg;

  // field widths
  localparam int BTN_W  = 16;
  localparam int AXIS_W = 16;
  localparam int DZ_W   = 15;

  // arithmetic widths
  localparam int SQ_W   = 32;           // x*x + y*y, root working registers
  localparam int MAG_W  = 16;           // |axis|, up to 32768
  localparam int PROD_W = MAG_W + DZ_W; // |axis| * (m - dz)
  localparam int NUM_W  = PROD_W + DZ_W; // times full scale
  localparam int DEN_W  = 2 * DZ_W;     // m * (full scale - dz)
  localparam int QUO_W  = 16;           // quotient never exceeds 32768
  localparam int STEP_W = 4;            // 16 root steps, 16 divide steps

  localparam logic [DZ_W-1:0] FULL_SCALE     = 15'h7FFF;
  localparam logic [DZ_W-1:0] DZ_LEFT_RESET  = 15'd7849;
  localparam logic [DZ_W-1:0] DZ_RIGHT_RESET = 15'd8689;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_LEFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_RIGHT = 1'b1;

  localparam int QUEUE_DEPTH_DEF = 2;

  // one classified sample, front to back
  typedef struct packed {
    logic [BTN_W-1:0]  held;
    logic [BTN_W-1:0]  presses;
    logic              query_held;
    logic              query_new;
    logic [AXIS_W-1:0] x;
    logic [AXIS_W-1:0] y;
    logic [DZ_W-1:0]   dz;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

@@ rtl/core/gsc_front.sv @@
module gsc_front import gsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DZ_W-1:0]      cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BTN_W-1:0]     buttons,
  input  logic [AXIS_W-1:0]    left_x_raw,
  input  logic [AXIS_W-1:0]    left_y_raw,
  input  logic [AXIS_W-1:0]    right_x_raw,
  input  logic [AXIS_W-1:0]    right_y_raw,
  input  logic [BTN_W-1:0]     query_mask,
  input  logic                 stick_select,
  input  queue_stat_t          q_stat,
  output logic                 push,
  output entry_t               push_entry
);

  logic [DZ_W-1:0]  dz_left;
  logic [DZ_W-1:0]  dz_right;
  logic [BTN_W-1:0] prev_buttons;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      dz_left      <= DZ_LEFT_RESET;
      dz_right     <= DZ_RIGHT_RESET;
      prev_buttons <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DZ_LEFT:  dz_left  <= cfg_data;
          REG_DZ_RIGHT: dz_right <= cfg_data;
          default: ;
        endcase
      end
      if (push) prev_buttons <= buttons;
    end
  end

  always_comb begin
    push_entry.held       = buttons;
    push_entry.presses    = buttons & ~prev_buttons;
    push_entry.query_held = |(buttons & query_mask);
    push_entry.query_new  = (|(buttons & query_mask)) && !(|(prev_buttons & query_mask));
    push_entry.x          = stick_select ? right_x_raw : left_x_raw;
    push_entry.y          = stick_select ? right_y_raw : left_y_raw;
    push_entry.dz         = stick_select ? dz_right : dz_left;
  end

endmodule

@@ rtl/core/gsc_fifo.sv @@
module gsc_fifo import gsc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  entry_t      push_entry,
  input  logic        pop,
  output entry_t      pop_entry,
  output queue_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  assign pop_entry  = slots[rd_ptr];
  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);

endmodule

@@ rtl/core/gsc_back.sv @@
module gsc_back import gsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  queue_stat_t       q_stat,
  input  entry_t            pop_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BTN_W-1:0]  held_buttons,
  output logic [BTN_W-1:0]  new_presses,
  output logic              query_held,
  output logic              query_new,
  output logic [AXIS_W-1:0] stick_x,
  output logic [AXIS_W-1:0] stick_y
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQX   = 9'b000000010,
    S_SQY   = 9'b000000100,
    S_ROOT  = 9'b000001000,
    S_CHECK = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_SCALE = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t             state;
  state_t             state_next;
  entry_t             cur;
  logic [SQ_W-1:0]    rem_v;
  logic [SQ_W-1:0]    root;
  logic [STEP_W-1:0]  step;
  logic [DZ_W-1:0]    mag_m;
  logic [DZ_W-1:0]    diff;
  logic [DEN_W-1:0]   den;
  logic [PROD_W-1:0]  prod;
  logic [NUM_W-1:0]   num;
  logic [QUO_W-1:0]   quo;
  logic               axis_y;
  logic [AXIS_W-1:0]  res_x;
  logic [AXIS_W-1:0]  res_y;

  logic               slot_free;
  logic               last_step;
  logic signed [AXIS_W-1:0]   sq_src;
  logic signed [2*AXIS_W-1:0] sq_prod;
  logic [SQ_W-1:0]    bit_val;
  logic [SQ_W:0]      trial_r;
  logic               ge_r;
  logic [SQ_W-1:0]    root_upd;
  logic [SQ_W-1:0]    rem_upd;
  logic               zero_out;
  logic [AXIS_W-1:0]  axis_val;
  logic [MAG_W-1:0]   axis_mag;
  logic [NUM_W-1:0]   trial_d;
  logic               ge_d;
  logic [QUO_W-1:0]   quo_upd;
  logic [AXIS_W-1:0]  scaled;

  assign slot_free = !out_valid || !out_stall;
  assign last_step = (step == '0);
  assign pop       = (state == S_IDLE) && !q_stat.empty;

  // squaring
  assign sq_src  = (state == S_SQX) ? $signed(cur.x) : $signed(cur.y);
  assign sq_prod = sq_src * sq_src;

  // one digit of the integer square root
  assign bit_val  = SQ_W'(1) << {step, 1'b0};
  assign trial_r  = {1'b0, root} + {1'b0, bit_val};
  assign ge_r     = {1'b0, rem_v} >= trial_r;
  assign root_upd = ge_r ? ((root >> 1) + bit_val) : (root >> 1);
  assign rem_upd  = ge_r ? (rem_v - trial_r[SQ_W-1:0]) : rem_v;

  assign zero_out = (cur.dz == FULL_SCALE) || (mag_m <= cur.dz);

  assign axis_val = axis_y ? cur.y : cur.x;
  assign axis_mag = axis_val[AXIS_W-1] ? (~axis_val + 1'b1) : axis_val;

  // one quotient bit of the restoring divider
  assign trial_d = NUM_W'(den) << step;
  assign ge_d    = num >= trial_d;
  assign quo_upd = quo | (QUO_W'(ge_d) << step);

  // sign and saturate, quotient is at most 32768
  always_comb begin
    if (axis_val[AXIS_W-1]) scaled = ~quo_upd + 1'b1;
    else if (quo_upd[QUO_W-1]) scaled = {1'b0, {(AXIS_W-1){1'b1}}};
    else scaled = quo_upd;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (!q_stat.empty) state_next = S_SQX;
      S_SQX:   state_next = S_SQY;
      S_SQY:   state_next = S_ROOT;
      S_ROOT:  if (last_step) state_next = S_CHECK;
      S_CHECK: state_next = zero_out ? S_DONE : S_MUL;
      S_MUL:   state_next = S_SCALE;
      S_SCALE: state_next = S_DIV;
      S_DIV:   if (last_step) state_next = axis_y ? S_DONE : S_MUL;
      S_DONE:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && slot_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur <= pop_entry;
      end
      S_SQX: begin
        rem_v <= SQ_W'(unsigned'(sq_prod));
      end
      S_SQY: begin
        rem_v <= rem_v + SQ_W'(unsigned'(sq_prod));
        root  <= '0;
        step  <= '1;
      end
      S_ROOT: begin
        rem_v <= rem_upd;
        root  <= root_upd;
        step  <= step - 1'b1;
        if (last_step) mag_m <= (root_upd > SQ_W'(FULL_SCALE)) ? FULL_SCALE : root_upd[DZ_W-1:0];
      end
      S_CHECK: begin
        den    <= DEN_W'(mag_m) * DEN_W'(FULL_SCALE - cur.dz);
        diff   <= mag_m - cur.dz;
        axis_y <= 1'b0;
        res_x  <= '0;
        res_y  <= '0;
      end
      S_MUL: begin
        prod <= PROD_W'(axis_mag) * PROD_W'(diff);
      end
      S_SCALE: begin
        num  <= {prod, {DZ_W{1'b0}}} - NUM_W'(prod);
        quo  <= '0;
        step <= '1;
      end
      S_DIV: begin
        if (ge_d) num <= num - trial_d;
        quo  <= quo_upd;
        step <= step - 1'b1;
        if (last_step) begin
          if (axis_y) res_y <= scaled;
          else res_x <= scaled;
          axis_y <= 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          held_buttons <= cur.held;
          new_presses  <= cur.presses;
          query_held   <= cur.query_held;
          query_new    <= cur.query_new;
          stick_x      <= res_x;
          stick_y      <= res_y;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/gamepad_sample_conditioner_unit.sv @@
// from input accept to result valid, a sample passes the queue, the squares, the 16-step
// square root and the dead zone test; outside the dead zone two 16-step divisions follow
// the back end finishes one item before it pops the next; the queue takes up to
// QUEUE_DEPTH items ahead while a result is computed or waits
// reset (rst, synchronous, active high) empties the queue, clears the previous button
// word and the output valid, and loads the dead zone registers with 7849 and 8689
module gamepad_sample_conditioner_unit import gsc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DZ_W-1:0]      cfg_data,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BTN_W-1:0]     buttons,
  input  logic [AXIS_W-1:0]    left_x_raw,
  input  logic [AXIS_W-1:0]    left_y_raw,
  input  logic [AXIS_W-1:0]    right_x_raw,
  input  logic [AXIS_W-1:0]    right_y_raw,
  input  logic [BTN_W-1:0]     query_mask,
  input  logic                 stick_select,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BTN_W-1:0]     held_buttons,
  output logic [BTN_W-1:0]     new_presses,
  output logic                 query_held,
  output logic                 query_new,
  output logic [AXIS_W-1:0]    stick_x,
  output logic [AXIS_W-1:0]    stick_y
);

  // front to back queue
  queue_stat_t q_stat;
  logic        push;
  entry_t      push_entry;
  logic        pop;
  entry_t      pop_entry;

  // front: config registers, button edge detect, query flags, stick select
  gsc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .buttons      (buttons),
    .left_x_raw   (left_x_raw),
    .left_y_raw   (left_y_raw),
    .right_x_raw  (right_x_raw),
    .right_y_raw  (right_y_raw),
    .query_mask   (query_mask),
    .stick_select (stick_select),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  // short queue so the sampler can run ahead of the root and divider until it is full
  gsc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .stat       (q_stat)
  );

  // back: squares, digit-serial root, dead zone test, rescale by restoring divide
  gsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .held_buttons (held_buttons),
    .new_presses  (new_presses),
    .query_held   (query_held),
    .query_new    (query_new),
    .stick_x      (stick_x),
    .stick_y      (stick_y)
  );

  // queue status is never full and empty at once
  a_queue_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // an accepted item is waiting in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !q_stat.empty)
    else $error("accepted item missing from queue");

  // a new query press is always a held query press
  a_query_new: assert property (@(posedge clk) disable iff (rst)
    (out_valid && query_new) |-> query_held)
    else $error("query_new without query_held");

  // new presses are a subset of held buttons
  a_press_subset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((new_presses & ~held_buttons) == '0))
    else $error("new press not held");

  // output channel comes out of reset empty
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

endmodule
